// File: hw/rtl/lmf_pkg.sv
// shared types, constants and saturation helpers of the limited mass flux remap unit
package lmf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned UnsW  = 31;
  localparam int unsigned QuotW = DataW + FracW;
  localparam int unsigned CntW  = 6;

  localparam logic signed [DataW-1:0] MaxV   = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] MinV   = 32'sh80000000;
  localparam logic signed [DataW-1:0] OneQ   = 32'sh00010000;
  localparam logic signed [DataW-1:0] TwoQ   = 32'sh00020000;
  // 2^16 / 6 rounded to nearest
  localparam logic signed [DataW-1:0] SixthQ = 32'sd10923;

  localparam logic [2:0] AddrTimeStep = 3'd0;

  typedef struct packed {
    logic                    sat;
    logic signed [DataW-1:0] val;
  } sat_val_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_ABS,
    ALU_MIN
  } alu_op_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_OV1,
    ST_OV2,
    ST_DFM,
    ST_DFI,
    ST_DFP,
    ST_PHI_ABS,
    ST_PHI_DIV,
    ST_PHI_WAIT,
    ST_T1_SUB,
    ST_T1_ABS,
    ST_T1_MUL,
    ST_T1_DIV,
    ST_T1_WAIT,
    ST_T2_ADD,
    ST_T2_ABS,
    ST_T2_MUL,
    ST_T2_DIV,
    ST_T2_WAIT,
    ST_DA_ADD,
    ST_DA_MUL,
    ST_LIM_ABS,
    ST_LIM_MUL,
    ST_LIM_ABS_I,
    ST_LIM_MIN_I,
    ST_LIM_ABS_U,
    ST_LIM_MIN_U,
    ST_DI,
    ST_DM_SUB,
    ST_DM_MUL,
    ST_DM_ADD,
    ST_DM_OV,
    ST_OUT,
    ST_SHIFT
  } st_e;

  // signed value from sign and magnitude, clamped to the data range
  function automatic sat_val_t from_mag(input logic neg, input logic [QuotW-1:0] m);
    sat_val_t r;
    r.sat = 1'b0;
    r.val = '0;
    if (!neg) begin
      if (m > QuotW'(MaxV)) begin
        r.sat = 1'b1;
        r.val = MaxV;
      end else begin
        r.val = m[DataW-1:0];
      end
    end else begin
      if (m > QuotW'({1'b0, MinV})) begin
        r.sat = 1'b1;
        r.val = MinV;
      end else begin
        r.val = DataW'('0) - m[DataW-1:0];
      end
    end
    return r;
  endfunction

  // one extra bit of sum clamped back to the data range
  function automatic sat_val_t clamp33(input logic signed [DataW:0] s);
    sat_val_t r;
    r.sat = (s[DataW] != s[DataW-1]);
    if (r.sat) begin
      r.val = s[DataW] ? MinV : MaxV;
    end else begin
      r.val = s[DataW-1:0];
    end
    return r;
  endfunction

  // magnitude of a signed value
  function automatic logic [DataW-1:0] mag32(input logic signed [DataW-1:0] v);
    return v[DataW-1] ? (DataW'('0) - v) : v;
  endfunction

endpackage

// File: hw/rtl/lmf_alu.sv
// shared saturating add, subtract, multiply, absolute value and minimum unit
module lmf_alu (
  input  lmf_pkg::alu_op_e                  op_i,
  input  logic signed [lmf_pkg::DataW-1:0]  a_i,
  input  logic signed [lmf_pkg::DataW-1:0]  b_i,
  output lmf_pkg::sat_val_t                 res_o
);

  logic signed [lmf_pkg::DataW:0]     sum;
  logic signed [lmf_pkg::DataW:0]     dif;
  logic [lmf_pkg::DataW-1:0]          ma;
  logic [lmf_pkg::DataW-1:0]          mb;
  logic [2*lmf_pkg::DataW-1:0]        prod;

  // operand prep
  always_comb begin
    sum  = {a_i[lmf_pkg::DataW-1], a_i} + {b_i[lmf_pkg::DataW-1], b_i};
    dif  = {a_i[lmf_pkg::DataW-1], a_i} - {b_i[lmf_pkg::DataW-1], b_i};
    ma   = lmf_pkg::mag32(a_i);
    mb   = lmf_pkg::mag32(b_i);
    prod = ma * mb;
  end

  // result select
  always_comb begin
    res_o.sat = 1'b0;
    res_o.val = '0;
    case (op_i)
      lmf_pkg::ALU_ADD: res_o = lmf_pkg::clamp33(sum);
      lmf_pkg::ALU_SUB: res_o = lmf_pkg::clamp33(dif);
      lmf_pkg::ALU_MUL: begin
        res_o = lmf_pkg::from_mag(a_i[lmf_pkg::DataW-1] ^ b_i[lmf_pkg::DataW-1],
                                  prod[2*lmf_pkg::DataW-1:lmf_pkg::FracW]);
      end
      lmf_pkg::ALU_ABS: res_o = lmf_pkg::from_mag(1'b0, lmf_pkg::QuotW'(ma));
      lmf_pkg::ALU_MIN: res_o.val = (a_i < b_i) ? a_i : b_i;
      default: res_o.val = '0;
    endcase
  end

endmodule

// File: hw/rtl/lmf_div.sv
// shared restoring divider for fixed point quotients, one quotient bit per cycle
module lmf_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lmf_pkg::DataW-1:0]  num_i,
  input  logic signed [lmf_pkg::DataW-1:0]  den_i,
  output logic                              done_o,
  output lmf_pkg::sat_val_t                 res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [lmf_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [lmf_pkg::QuotW-1:0]     sh_q, sh_d;
  logic [lmf_pkg::DataW-1:0]     rem_q, rem_d;
  logic [lmf_pkg::DataW-1:0]     mb_q, mb_d;
  logic                          neg_q, neg_d;
  lmf_pkg::sat_val_t             res_q, res_d;
  logic [lmf_pkg::DataW:0]       rem_sh;
  logic [lmf_pkg::DataW:0]       rem_sub;
  logic                          ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, sh_q[lmf_pkg::QuotW-1]};
    rem_sub = rem_sh - {1'b0, mb_q};
    ge      = (rem_sh >= {1'b0, mb_q});
  end

  // next values
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (start_i) begin
      if (den_i == '0) begin
        // divide by zero clamps by sign of the numerator
        done_d    = 1'b1;
        res_d.sat = 1'b1;
        res_d.val = num_i[lmf_pkg::DataW-1] ? lmf_pkg::MinV : lmf_pkg::MaxV;
      end else begin
        busy_d = 1'b1;
        cnt_d  = lmf_pkg::CntW'(lmf_pkg::QuotW - 1);
        sh_d   = {lmf_pkg::mag32(num_i), lmf_pkg::FracW'(0)};
        rem_d  = '0;
        mb_d   = lmf_pkg::mag32(den_i);
        neg_d  = num_i[lmf_pkg::DataW-1] ^ den_i[lmf_pkg::DataW-1];
      end
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[lmf_pkg::DataW-1:0] : rem_sh[lmf_pkg::DataW-1:0];
      sh_d  = {sh_q[lmf_pkg::QuotW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = lmf_pkg::from_mag(neg_q, {sh_q[lmf_pkg::QuotW-2:0], ge});
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hw/rtl/limited_mass_flux_remap_unit.sv
// top level: window of past cells, step sequencer, shared units and output register
//
// Streams the cells of one x line, one cell per input beat, and gives the van Leer
// limited upwind mass flux through the face two cells back once four cells of the
// line are in (line_start restarts the window). One cell is worked at a time and
// in_ready_o is low meanwhile. A cell that yields a flux runs three 48-step divisions
// on the single shared divider, each with start and done, and further steps of the
// shared add, multiply and compare unit. The result sits in an output register, so
// the next cell is taken while a flux still waits. time_step is at byte address 0.
module limited_mass_flux_remap_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // cell input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              line_start_i,
  input  logic signed [lmf_pkg::DataW-1:0]  vel_a_i,
  input  logic signed [lmf_pkg::DataW-1:0]  vel_b_i,
  input  logic signed [lmf_pkg::DataW-1:0]  vel_c_i,
  input  logic signed [lmf_pkg::DataW-1:0]  vel_d_i,
  input  logic [lmf_pkg::UnsW-1:0]          face_area_i,
  input  logic [lmf_pkg::UnsW-1:0]          density_i,
  input  logic [lmf_pkg::UnsW-1:0]          vertex_volume_i,
  input  logic [lmf_pkg::UnsW-1:0]          cell_volume_i,
  // flux output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lmf_pkg::DataW-1:0]  mass_flux_o,
  output logic                              saturated_o
);

  localparam int unsigned W = lmf_pkg::DataW;
  localparam int unsigned U = lmf_pkg::UnsW;

  lmf_pkg::st_e             st_q, st_d;
  logic [U-1:0]             ts_q;
  logic                     in_acc;
  logic                     cfg_wr;

  // window of past cells, index 0 is the previous cell
  logic [U-1:0]             pd_q  [3];
  logic [U-1:0]             pvv_q [3];
  logic [U-1:0]             pcv_q [2];
  logic signed [W-1:0]      pva_q [2];
  logic signed [W-1:0]      psv_q [2];
  logic                     psf_q [2];
  logic [1:0]               fill_q;

  // current cell and working registers
  logic [U-1:0]             dens_q, vvol_q, cvol_q, area_q;
  logic signed [W-1:0]      vavg_q;
  logic signed [W-1:0]      ov_q;
  logic                     ovf_q;
  logic signed [W-1:0]      dfm_q, dfi_q, dfp_q, phi_q, t1_q, tmp_q, tmp2_q;
  logic                     sat_q;
  logic signed [W+1:0]      vsum;

  // output register
  logic                     out_valid_q;
  logic signed [W-1:0]      flux_q;
  logic                     satf_q;
  logic                     out_free;

  // shared units
  lmf_pkg::alu_op_e         alu_op;
  logic signed [W-1:0]      alu_a, alu_b;
  lmf_pkg::sat_val_t        alu_res;
  logic                     div_start;
  logic signed [W-1:0]      div_num, div_den;
  logic                     div_done;
  lmf_pkg::sat_val_t        div_res;

  // face operands
  logic                     up;
  logic signed [W-1:0]      fm, fi, fp, fp2, fu, dfu, dxci, dxcu, dxbu;
  logic                     ss_pos, ss_neg;

  assign in_ready_o = (st_q == lmf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready && (paddr == lmf_pkg::AddrTimeStep);
  assign prdata     = (paddr == lmf_pkg::AddrTimeStep) ? {1'b0, ts_q} : '0;

  assign vsum = {{2{vel_a_i[W-1]}}, vel_a_i} + {{2{vel_b_i[W-1]}}, vel_b_i}
              + {{2{vel_c_i[W-1]}}, vel_c_i} + {{2{vel_d_i[W-1]}}, vel_d_i};

  // face i uses cells i-1 .. i+2
  always_comb begin
    up     = !pva_q[1][W-1];
    fm     = {1'b0, pd_q[2]};
    fi     = {1'b0, pd_q[1]};
    fp     = {1'b0, pd_q[0]};
    fp2    = {1'b0, dens_q};
    fu     = up ? fi : fp;
    dfu    = up ? dfm_q : dfp_q;
    dxci   = {1'b0, pvv_q[1]};
    dxcu   = up ? {1'b0, pvv_q[2]} : {1'b0, pvv_q[0]};
    dxbu   = up ? {1'b0, pcv_q[1]} : {1'b0, pcv_q[0]};
    ss_pos = (up && !dfi_q[W-1] && !dfu[W-1]) || (!up && dfi_q[W-1] && dfu[W-1]);
    ss_neg = (up && dfi_q[W-1] && dfu[W-1]) || (!up && !dfi_q[W-1] && !dfu[W-1]);
  end

  lmf_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  lmf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      lmf_pkg::ST_IDLE:      if (in_acc) st_d = lmf_pkg::ST_OV1;
      lmf_pkg::ST_OV1:       st_d = lmf_pkg::ST_OV2;
      lmf_pkg::ST_OV2:       st_d = (fill_q == 2'd3) ? lmf_pkg::ST_DFM : lmf_pkg::ST_SHIFT;
      lmf_pkg::ST_DFM:       st_d = lmf_pkg::ST_DFI;
      lmf_pkg::ST_DFI:       st_d = lmf_pkg::ST_DFP;
      lmf_pkg::ST_DFP:       st_d = lmf_pkg::ST_PHI_ABS;
      lmf_pkg::ST_PHI_ABS:   st_d = lmf_pkg::ST_PHI_DIV;
      lmf_pkg::ST_PHI_DIV:   st_d = lmf_pkg::ST_PHI_WAIT;
      lmf_pkg::ST_PHI_WAIT:  if (div_done) st_d = lmf_pkg::ST_T1_SUB;
      lmf_pkg::ST_T1_SUB:    st_d = lmf_pkg::ST_T1_ABS;
      lmf_pkg::ST_T1_ABS:    st_d = lmf_pkg::ST_T1_MUL;
      lmf_pkg::ST_T1_MUL:    st_d = lmf_pkg::ST_T1_DIV;
      lmf_pkg::ST_T1_DIV:    st_d = lmf_pkg::ST_T1_WAIT;
      lmf_pkg::ST_T1_WAIT:   if (div_done) st_d = lmf_pkg::ST_T2_ADD;
      lmf_pkg::ST_T2_ADD:    st_d = lmf_pkg::ST_T2_ABS;
      lmf_pkg::ST_T2_ABS:    st_d = lmf_pkg::ST_T2_MUL;
      lmf_pkg::ST_T2_MUL:    st_d = lmf_pkg::ST_T2_DIV;
      lmf_pkg::ST_T2_DIV:    st_d = lmf_pkg::ST_T2_WAIT;
      lmf_pkg::ST_T2_WAIT:   if (div_done) st_d = lmf_pkg::ST_DA_ADD;
      lmf_pkg::ST_DA_ADD:    st_d = lmf_pkg::ST_DA_MUL;
      lmf_pkg::ST_DA_MUL:    st_d = lmf_pkg::ST_LIM_ABS;
      lmf_pkg::ST_LIM_ABS:   st_d = lmf_pkg::ST_LIM_MUL;
      lmf_pkg::ST_LIM_MUL:   st_d = lmf_pkg::ST_LIM_ABS_I;
      lmf_pkg::ST_LIM_ABS_I: st_d = lmf_pkg::ST_LIM_MIN_I;
      lmf_pkg::ST_LIM_MIN_I: st_d = lmf_pkg::ST_LIM_ABS_U;
      lmf_pkg::ST_LIM_ABS_U: st_d = lmf_pkg::ST_LIM_MIN_U;
      lmf_pkg::ST_LIM_MIN_U: st_d = lmf_pkg::ST_DI;
      lmf_pkg::ST_DI:        st_d = lmf_pkg::ST_DM_SUB;
      lmf_pkg::ST_DM_SUB:    st_d = lmf_pkg::ST_DM_MUL;
      lmf_pkg::ST_DM_MUL:    st_d = lmf_pkg::ST_DM_ADD;
      lmf_pkg::ST_DM_ADD:    st_d = lmf_pkg::ST_DM_OV;
      lmf_pkg::ST_DM_OV:     st_d = lmf_pkg::ST_OUT;
      lmf_pkg::ST_OUT:       if (out_free) st_d = lmf_pkg::ST_SHIFT;
      lmf_pkg::ST_SHIFT:     st_d = lmf_pkg::ST_IDLE;
      default:               st_d = lmf_pkg::ST_IDLE;
    endcase
  end

  // shared unit operands per step
  always_comb begin
    alu_op    = lmf_pkg::ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    div_start = 1'b0;
    div_num   = tmp_q;
    div_den   = dxbu;
    case (st_q)
      lmf_pkg::ST_OV1: begin
        alu_op = lmf_pkg::ALU_MUL; alu_a = vavg_q; alu_b = {1'b0, ts_q};
      end
      lmf_pkg::ST_OV2: begin
        alu_op = lmf_pkg::ALU_MUL; alu_a = tmp_q; alu_b = {1'b0, area_q};
      end
      lmf_pkg::ST_DFM: begin
        alu_op = lmf_pkg::ALU_SUB; alu_a = fi; alu_b = fm;
      end
      lmf_pkg::ST_DFI: begin
        alu_op = lmf_pkg::ALU_SUB; alu_a = fp; alu_b = fi;
      end
      lmf_pkg::ST_DFP: begin
        alu_op = lmf_pkg::ALU_SUB; alu_a = fp2; alu_b = fp;
      end
      lmf_pkg::ST_PHI_ABS: begin
        alu_op = lmf_pkg::ALU_ABS; alu_a = psv_q[1];
      end
      lmf_pkg::ST_PHI_DIV: begin
        div_start = 1'b1; div_den = dxbu;
      end
      lmf_pkg::ST_T1_SUB: begin
        alu_op = lmf_pkg::ALU_SUB; alu_a = lmf_pkg::TwoQ; alu_b = phi_q;
      end
      lmf_pkg::ST_T1_ABS, lmf_pkg::ST_LIM_ABS_I: begin
        alu_op = lmf_pkg::ALU_ABS; alu_a = dfi_q;
      end
      lmf_pkg::ST_T1_MUL, lmf_pkg::ST_T2_MUL, lmf_pkg::ST_DM_MUL: begin
        alu_op = lmf_pkg::ALU_MUL; alu_a = tmp_q; alu_b = tmp2_q;
      end
      lmf_pkg::ST_T1_DIV: begin
        div_start = 1'b1; div_den = dxci;
      end
      lmf_pkg::ST_T2_ADD: begin
        alu_op = lmf_pkg::ALU_ADD; alu_a = lmf_pkg::OneQ; alu_b = phi_q;
      end
      lmf_pkg::ST_T2_ABS, lmf_pkg::ST_LIM_ABS_U: begin
        alu_op = lmf_pkg::ALU_ABS; alu_a = dfu;
      end
      lmf_pkg::ST_T2_DIV: begin
        div_start = 1'b1; div_den = dxcu;
      end
      lmf_pkg::ST_DA_ADD: begin
        alu_op = lmf_pkg::ALU_ADD; alu_a = t1_q; alu_b = tmp_q;
      end
      lmf_pkg::ST_DA_MUL: begin
        alu_op = lmf_pkg::ALU_MUL; alu_a = tmp_q; alu_b = lmf_pkg::SixthQ;
      end
      lmf_pkg::ST_LIM_ABS: begin
        alu_op = lmf_pkg::ALU_ABS; alu_a = tmp_q;
      end
      lmf_pkg::ST_LIM_MUL: begin
        alu_op = lmf_pkg::ALU_MUL; alu_a = tmp_q; alu_b = dxbu;
      end
      lmf_pkg::ST_LIM_MIN_I, lmf_pkg::ST_LIM_MIN_U: begin
        alu_op = lmf_pkg::ALU_MIN; alu_a = tmp_q; alu_b = tmp2_q;
      end
      lmf_pkg::ST_DI: begin
        alu_op = lmf_pkg::ALU_SUB;
        alu_a  = ss_pos ? tmp_q : '0;
        alu_b  = ss_neg ? tmp_q : '0;
      end
      lmf_pkg::ST_DM_SUB: begin
        alu_op = lmf_pkg::ALU_SUB; alu_a = lmf_pkg::OneQ; alu_b = phi_q;
      end
      lmf_pkg::ST_DM_ADD: begin
        alu_op = lmf_pkg::ALU_ADD; alu_a = fu; alu_b = tmp_q;
      end
      lmf_pkg::ST_DM_OV: begin
        alu_op = lmf_pkg::ALU_MUL; alu_a = tmp_q; alu_b = psv_q[1];
      end
      default: begin
        alu_op = lmf_pkg::ALU_ADD;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lmf_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // time step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= '0;
    end else if (cfg_wr) begin
      ts_q <= pwdata[U-1:0];
    end
  end

  // window: cleared on reset and at line start, shifted after each cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        pd_q[k]  <= '0;
        pvv_q[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        pcv_q[k] <= '0;
        pva_q[k] <= '0;
        psv_q[k] <= '0;
        psf_q[k] <= 1'b0;
      end
      fill_q <= '0;
    end else if (in_acc && line_start_i) begin
      for (int k = 0; k < 3; k++) begin
        pd_q[k]  <= '0;
        pvv_q[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        pcv_q[k] <= '0;
        pva_q[k] <= '0;
        psv_q[k] <= '0;
        psf_q[k] <= 1'b0;
      end
      fill_q <= '0;
    end else if (st_q == lmf_pkg::ST_SHIFT) begin
      pd_q[2]  <= pd_q[1];
      pd_q[1]  <= pd_q[0];
      pd_q[0]  <= dens_q;
      pvv_q[2] <= pvv_q[1];
      pvv_q[1] <= pvv_q[0];
      pvv_q[0] <= vvol_q;
      pcv_q[1] <= pcv_q[0];
      pcv_q[0] <= cvol_q;
      pva_q[1] <= pva_q[0];
      pva_q[0] <= vavg_q;
      psv_q[1] <= psv_q[0];
      psv_q[0] <= ov_q;
      psf_q[1] <= psf_q[0];
      psf_q[0] <= ovf_q;
      if (fill_q != 2'd3) begin
        fill_q <= fill_q + 2'd1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dens_q <= density_i;
      vvol_q <= vertex_volume_i;
      cvol_q <= cell_volume_i;
      area_q <= face_area_i;
      // floor division of the velocity sum by four
      vavg_q <= vsum[W+1:2];
    end
    case (st_q)
      lmf_pkg::ST_OV1: begin
        tmp_q <= alu_res.val;
        ovf_q <= alu_res.sat;
      end
      lmf_pkg::ST_OV2: begin
        ov_q  <= alu_res.val;
        ovf_q <= ovf_q | alu_res.sat;
      end
      lmf_pkg::ST_DFM: begin
        dfm_q <= alu_res.val;
        sat_q <= psf_q[1] | alu_res.sat;
      end
      lmf_pkg::ST_DFI: begin
        dfi_q <= alu_res.val;
        sat_q <= sat_q | alu_res.sat;
      end
      lmf_pkg::ST_DFP: begin
        dfp_q <= alu_res.val;
        sat_q <= sat_q | alu_res.sat;
      end
      lmf_pkg::ST_PHI_WAIT: begin
        if (div_done) begin
          phi_q <= div_res.val;
          sat_q <= sat_q | div_res.sat;
        end
      end
      lmf_pkg::ST_T1_WAIT: begin
        if (div_done) begin
          t1_q  <= div_res.val;
          sat_q <= sat_q | div_res.sat;
        end
      end
      lmf_pkg::ST_T2_WAIT: begin
        if (div_done) begin
          tmp_q <= div_res.val;
          sat_q <= sat_q | div_res.sat;
        end
      end
      lmf_pkg::ST_T1_ABS, lmf_pkg::ST_T2_ABS, lmf_pkg::ST_LIM_ABS_I,
      lmf_pkg::ST_LIM_ABS_U, lmf_pkg::ST_DM_SUB: begin
        tmp2_q <= alu_res.val;
        sat_q  <= sat_q | alu_res.sat;
      end
      lmf_pkg::ST_PHI_ABS, lmf_pkg::ST_T1_SUB, lmf_pkg::ST_T1_MUL, lmf_pkg::ST_T2_ADD,
      lmf_pkg::ST_T2_MUL, lmf_pkg::ST_DA_ADD, lmf_pkg::ST_DA_MUL, lmf_pkg::ST_LIM_ABS,
      lmf_pkg::ST_LIM_MUL, lmf_pkg::ST_LIM_MIN_I, lmf_pkg::ST_LIM_MIN_U, lmf_pkg::ST_DI,
      lmf_pkg::ST_DM_MUL, lmf_pkg::ST_DM_ADD, lmf_pkg::ST_DM_OV: begin
        tmp_q <= alu_res.val;
        sat_q <= sat_q | alu_res.sat;
      end
      default: begin
        sat_q <= sat_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == lmf_pkg::ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == lmf_pkg::ST_OUT && out_free) begin
      flux_q <= tmp_q;
      satf_q <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mass_flux_o = flux_q;
  assign saturated_o = satf_q;

endmodule

// File: hw/rtl/lmf_checker.sv
// port level checks of the limited mass flux remap unit and their bind
module lmf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [lmf_pkg::DataW-1:0]  mass_flux_o,
  input logic                              pready
);

  // a stalled flux beat holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mass_flux_o))
    else $error("flux beat dropped or changed while stalled");

  // one cell at a time: busy right after a cell is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a cell is in work");

  // a new flux only appears while a cell is still in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("flux appeared while idle");

  // configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind limited_mass_flux_remap_unit lmf_checker u_lmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .mass_flux_o (mass_flux_o),
  .pready      (pready)
);

// File: sim/tb_limited_mass_flux_remap_unit.sv
// testbench of the limited mass flux remap unit: cell stream driver, flux predictor and checker
`timescale 1ns / 100ps

module tb_limited_mass_flux_remap_unit;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 250;

  typedef struct {
    bit                ls;
    logic signed [31:0] va, vb, vc, vd;
    logic [30:0]       area, dens, vvol, cvol;
  } cell_t;

  typedef struct {
    logic signed [31:0] flux;
    bit                 sat;
  } flux_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] mass_flux_o;
  logic saturated_o;

  cell_t cur = '{default: '0};
  logic line_start_i;
  logic signed [31:0] vel_a_i, vel_b_i, vel_c_i, vel_d_i;
  logic [30:0] face_area_i, density_i, vertex_volume_i, cell_volume_i;

  assign line_start_i    = cur.ls;
  assign vel_a_i         = cur.va;
  assign vel_b_i         = cur.vb;
  assign vel_c_i         = cur.vc;
  assign vel_d_i         = cur.vd;
  assign face_area_i     = cur.area;
  assign density_i       = cur.dens;
  assign vertex_volume_i = cur.vvol;
  assign cell_volume_i   = cur.cvol;

  limited_mass_flux_remap_unit DUT (.*);

  always #6 clk_i = ~clk_i;

  cell_t cell_q[$];
  flux_t flux_q[$];
  bit failed = 1'b0;
  bit in_taken = 1'b0;
  bit last_phase = 1'b0;
  int cells_taken = 0;

  // predictor state
  longint step_dt = 0;
  longint win_dens[3], win_vvol[3], win_cvol[2], win_vavg[2], win_swept[2];
  bit win_sflag[2];
  int win_fill = 0;
  bit sat_acc;

  function automatic longint q_clamp(longint v);
    if (v > QMax) begin
      sat_acc = 1'b1;
      return QMax;
    end
    if (v < QMin) begin
      sat_acc = 1'b1;
      return QMin;
    end
    return v;
  endfunction

  function automatic longint q_mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint q_from_mag(bit neg, longint m);
    if (!neg) return q_clamp(m);
    return q_clamp(-m);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return q_from_mag((a < 0) != (b < 0), (q_mag(a) * q_mag(b)) >> 16);
  endfunction

  function automatic longint q_div(longint a, longint b);
    if (b == 0) begin
      sat_acc = 1'b1;
      return a < 0 ? QMin : QMax;
    end
    return q_from_mag((a < 0) != (b < 0), (q_mag(a) << 16) / q_mag(b));
  endfunction

  function automatic longint q_abs(longint v);
    return q_clamp(q_mag(v));
  endfunction

  function automatic void window_clear();
    for (int k = 0; k < 3; k++) begin
      win_dens[k] = 0;
      win_vvol[k] = 0;
    end
    for (int k = 0; k < 2; k++) begin
      win_cvol[k] = 0;
      win_vavg[k] = 0;
      win_swept[k] = 0;
      win_sflag[k] = 0;
    end
    win_fill = 0;
  endfunction

  // advance the window by one cell, return 1 with the flux once the window is full
  function automatic bit flux_predict(cell_t c, output flux_t r);
    longint s, vavg, ov, fm, fi, fp, fp2, dfm, dfi, dfp, fu, dfu, dxci, dxcu, dxbu;
    longint phi, t1, t2, da, lim, di, dm;
    bit ovf, up, got;
    int ss;
    got = 0;
    r = '{flux: '0, sat: 0};
    if (c.ls) window_clear();
    sat_acc = 0;
    s = longint'(c.va) + longint'(c.vb) + longint'(c.vc) + longint'(c.vd);
    vavg = q_clamp(s >>> 2);
    ov = q_mul(q_mul(vavg, step_dt), longint'(c.area));
    ovf = sat_acc;
    if (win_fill >= 3) begin
      fm = win_dens[2];
      fi = win_dens[1];
      fp = win_dens[0];
      fp2 = longint'(c.dens);
      up = win_vavg[1] >= 0;
      sat_acc = win_sflag[1];
      dfm = q_clamp(fi - fm);
      dfi = q_clamp(fp - fi);
      dfp = q_clamp(fp2 - fp);
      fu = up ? fi : fp;
      dfu = up ? dfm : dfp;
      dxci = win_vvol[1];
      dxcu = up ? win_vvol[2] : win_vvol[0];
      dxbu = up ? win_cvol[1] : win_cvol[0];
      phi = q_div(q_abs(win_swept[1]), dxbu);
      t1 = q_div(q_mul(q_clamp(longint'(lmf_pkg::TwoQ) - phi), q_abs(dfi)), dxci);
      t2 = q_div(q_mul(q_clamp(longint'(lmf_pkg::OneQ) + phi), q_abs(dfu)), dxcu);
      da = q_mul(q_clamp(t1 + t2), longint'(lmf_pkg::SixthQ));
      // limiter sign: same slope sign on both sides, flipped for downwind flow
      if (dfi >= 0 && dfu >= 0) ss = 1;
      else if (dfi < 0 && dfu < 0) ss = -1;
      else ss = 0;
      if (!up) ss = -ss;
      lim = q_mul(q_abs(da), dxbu);
      if (q_abs(dfi) < lim) lim = q_abs(dfi);
      if (q_abs(dfu) < lim) lim = q_abs(dfu);
      di = ss > 0 ? lim : (ss < 0 ? -lim : 0);
      dm = q_mul(q_clamp(fu + q_mul(di, q_clamp(longint'(lmf_pkg::OneQ) - phi))),
                 win_swept[1]);
      r.flux = dm[31:0];
      r.sat = sat_acc;
      got = 1;
    end
    win_dens[2] = win_dens[1];
    win_dens[1] = win_dens[0];
    win_dens[0] = longint'(c.dens);
    win_vvol[2] = win_vvol[1];
    win_vvol[1] = win_vvol[0];
    win_vvol[0] = longint'(c.vvol);
    win_cvol[1] = win_cvol[0];
    win_cvol[0] = longint'(c.cvol);
    win_vavg[1] = win_vavg[0];
    win_vavg[0] = vavg;
    win_swept[1] = win_swept[0];
    win_swept[0] = ov;
    win_sflag[1] = win_sflag[0];
    win_sflag[0] = ovf;
    if (win_fill < 3) win_fill++;
    return got;
  endfunction

  // cell sender with random gaps, quiet near the end
  int send_gap = 0;
  always @(negedge clk_i) begin
    bit nv;
    cell_t nc;
    nv = in_valid_i;
    nc = cur;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nv = 0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (cell_q.size() > 0) begin
        if (!(last_phase && cell_q.size() < 80) && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 2);
        end else begin
          nc = cell_q.pop_front();
          nv = 1;
        end
      end
    end
    in_valid_i <= nv;
    cur <= nc;
  end

  // flux receiver with random stalls and one long hold-off
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk_i) begin
    bit nr;
    nr = 1;
    if (!hold_done && cells_taken >= 120) begin
      hold_done = 1;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      nr = 0;
    end else if (!(last_phase && cell_q.size() < 80) && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 2);
      nr = 0;
    end
    out_ready_i <= rst_ni && nr;
  end

  // beat monitor: predict on accepted cells, check accepted fluxes
  always @(posedge clk_i) begin
    flux_t r, e;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      cells_taken++;
      if (flux_predict(cur, r)) flux_q.push_back(r);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flux_q.size() == 0) begin
        $error("unexpected flux beat mass_flux=%0d", mass_flux_o);
        failed = 1;
      end else begin
        e = flux_q.pop_front();
        if (mass_flux_o !== e.flux) begin
          $error("mass_flux expected %0d actual %0d", e.flux, mass_flux_o);
          failed = 1;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, saturated_o);
          failed = 1;
        end
      end
    end
  end

  // watchdog on cycles without any beat while work is outstanding
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt = 0;
    end else if (cell_q.size() > 0 || in_valid_i || flux_q.size() > 0) begin
      stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [30:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= lmf_pkg::AddrTimeStep;
    pwdata <= {1'b0, val};
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    step_dt = longint'(val);
    // read back
    @(negedge clk_i);
    psel <= 1;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    if (rd[30:0] !== val) begin
      $error("time_step expected %0h actual %0h", val, rd[30:0]);
      failed = 1;
    end
  endtask

  task automatic drain();
    while (cell_q.size() > 0 || in_valid_i || flux_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic cell_t mk_cell(bit ls, logic signed [31:0] v, logic [30:0] dens,
                                    logic [30:0] vv, logic [30:0] cv, logic [30:0] area);
    cell_t c;
    c.ls = ls;
    c.va = v;
    c.vb = v;
    c.vc = v;
    c.vd = v;
    c.dens = dens;
    c.vvol = vv;
    c.cvol = cv;
    c.area = area;
    return c;
  endfunction

  // plausible cell, with a field now and then taken fully at random
  function automatic cell_t rand_cell(bit ls, bit wild);
    cell_t c;
    c.ls = ls;
    c.va = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    c.vb = c.va + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
    c.vc = c.va + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
    c.vd = c.va + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
    c.area = 31'($urandom_range(32'h1000, 32'h20000));
    c.dens = 31'($urandom_range(32'h1000, 32'h40000));
    c.vvol = $urandom_range(0, 19) == 0 ? 31'd0 : 31'($urandom_range(32'h4000, 32'h40000));
    c.cvol = $urandom_range(0, 19) == 0 ? 31'd0 : 31'($urandom_range(32'h4000, 32'h40000));
    if (wild || $urandom_range(0, 9) == 0) c.va = $urandom;
    if (wild || $urandom_range(0, 9) == 0) c.vb = $urandom;
    if (wild || $urandom_range(0, 9) == 0) c.vc = $urandom;
    if (wild || $urandom_range(0, 9) == 0) c.vd = $urandom;
    if (wild || $urandom_range(0, 9) == 0) c.area = 31'($urandom);
    if (wild || $urandom_range(0, 9) == 0) c.dens = 31'($urandom);
    if (wild || $urandom_range(0, 9) == 0) c.vvol = 31'($urandom);
    if (wild || $urandom_range(0, 9) == 0) c.cvol = 31'($urandom);
    return c;
  endfunction

  // mostly whole lines, some stray cells
  task automatic queue_lines(int n);
    int len;
    while (n > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        cell_q.push_back(rand_cell(1'($urandom_range(0, 1)), 1));
        n--;
      end else begin
        len = $urandom_range(4, 10);
        for (int k = 0; k < len; k++) cell_q.push_back(rand_cell(k == 0, 0));
        n -= len;
      end
    end
  endtask

  initial begin
    window_clear();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed cells
    reg_write(31'h10000);
    cell_q.push_back(mk_cell(1, 32'sh10000, 31'h10000, 31'h10000, 31'h10000, 31'h10000));
    cell_q.push_back(mk_cell(0, 32'sh8000, 31'h20000, 31'h18000, 31'h14000, 31'h10000));
    cell_q.push_back(mk_cell(0, 32'sh4000, 31'h18000, 31'h10000, 31'h20000, 31'h8000));
    cell_q.push_back(mk_cell(0, -32'sh8000, 31'h8000, 31'h10000, 31'h10000, 31'h10000));
    cell_q.push_back(mk_cell(0, -32'sh10000, 31'h30000, 31'h20000, 31'h10000, 31'h10000));
    cell_q.push_back(mk_cell(0, 32'sh0, 31'h10000, 31'h0, 31'h0, 31'h10000));
    cell_q.push_back(mk_cell(0, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                             31'h7fffffff));
    cell_q.push_back(mk_cell(0, 32'sh80000000, 31'h0, 31'h1, 31'h1, 31'h7fffffff));
    cell_q.push_back(mk_cell(0, 32'sh80000000, 31'h7fffffff, 31'h0, 31'h7fffffff, 31'h1));
    cell_q.push_back(mk_cell(0, 32'sh12345, 31'h0, 31'h10000, 31'h0, 31'h0));
    // short line restarted before the window fills
    cell_q.push_back(mk_cell(1, 32'sh10000, 31'h10000, 31'h10000, 31'h10000, 31'h10000));
    cell_q.push_back(mk_cell(0, 32'sh10000, 31'h10000, 31'h10000, 31'h10000, 31'h10000));
    cell_q.push_back(mk_cell(1, -32'sh20000, 31'h40000, 31'h8000, 31'h8000, 31'h10000));
    cell_q.push_back(mk_cell(0, -32'sh20000, 31'h30000, 31'h8000, 31'h8000, 31'h10000));
    cell_q.push_back(mk_cell(0, -32'sh20000, 31'h20000, 31'h8000, 31'h8000, 31'h10000));
    cell_q.push_back(mk_cell(0, -32'sh20000, 31'h10000, 31'h8000, 31'h8000, 31'h10000));
    // line continues without a new start
    cell_q.push_back(mk_cell(0, 32'sh30000, 31'h20000, 31'h8000, 31'h8000, 31'h10000));
    cell_q.push_back(rand_cell(0, 1));
    drain();

    // random phases over several time steps, extremes included
    reg_write(31'h7fffffff);
    queue_lines(140);
    drain();
    reg_write(31'h0);
    queue_lines(120);
    drain();
    reg_write(31'h4000);
    queue_lines(160);
    drain();
    reg_write(31'($urandom));
    queue_lines(140);
    drain();
    reg_write(31'h10000);
    last_phase = 1;
    queue_lines(180);
    drain();

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
